@@ src/tach_pkg.sv @@
`default_nettype none

package tach_pkg;

    // defaults of the top level parameters
    localparam int CLOCK_HZ_DEF   = 80000000;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    // fixed field widths
    localparam int STAMP_W    = 32;
    localparam int RPM_W      = 41;
    localparam int FREQ_W     = 35;
    localparam int PP_W       = 8;
    localparam int WIN_REG_W  = 5;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PP_W-1:0]      PP_RESET      = PP_W'(1);
    localparam logic [WIN_REG_W-1:0] WIN_RESET     = WIN_REG_W'(1);
    localparam logic [MS_W-1:0]      TIMEOUT_RESET = MS_W'(1000);
    localparam logic [MS_W-1:0]      MS_MAX        = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLE_PAIRS   = 2'd0,
        CFG_FILTER_WIN   = 2'd1,
        CFG_FILTER_EN    = 2'd2,
        CFG_STOP_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FUNC_CAPTURE = 1'b0,
        FUNC_TICK    = 1'b1
    } t_func;

endpackage

`default_nettype wire

@@ src/tach_rpm_meter_with_moving_average.sv @@
// tick, priming capture or zero period: result goes by way of S_OUT into the output register
// measuring capture: two runs of the shared restoring divider (frequency, rpm), and a third
// for the average when filtered, with sequencer states between them
// one transaction at a time; the next is taken once the result sits in the output register
// reset is synchronous, active low: registers to defaults, filter empty, held results zero, out valid low
// the ring needs no clearing pass, entries are masked by the fill count
`default_nettype none

module tach_rpm_meter_with_moving_average #(
    parameter int CLOCK_HZ   = tach_pkg::CLOCK_HZ_DEF,
    parameter int MAX_WINDOW = tach_pkg::MAX_WINDOW_DEF,
    parameter int STAMP_BITS = tach_pkg::STAMP_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_func,
    input  wire logic [tach_pkg::STAMP_W-1:0]    i_capture_stamp,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [tach_pkg::RPM_W-1:0]      o_filtered_rpm,
    output logic      [tach_pkg::RPM_W-1:0]      o_raw_rpm,
    output logic      [tach_pkg::FREQ_W-1:0]     o_input_frequency,
    output logic                                 o_new_measurement,
    output logic                                 o_stopped,
    input  wire logic                            i_cfg_wen,
    input  wire logic [tach_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tach_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import tach_pkg::*;

    localparam longint NUM_FREQ  = longint'(CLOCK_HZ) * 256;
    localparam longint NUM_RPM   = longint'(CLOCK_HZ) * 15360;
    localparam int     NUM_RPM_W = $clog2(NUM_RPM + 1);
    localparam int     IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int     WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int     SUM_W     = RPM_W + $clog2(MAX_WINDOW);
    localparam int     DIVD_A    = (SUM_W > NUM_RPM_W) ? SUM_W : NUM_RPM_W;
    localparam int     DIVD_W    = (DIVD_A > RPM_W) ? DIVD_A : RPM_W + 1;
    localparam int     DIVS_W    = STAMP_BITS + PP_W;

    localparam logic [DIVD_W-1:0] NUM_FREQ_V = DIVD_W'(NUM_FREQ);
    localparam logic [DIVD_W-1:0] NUM_RPM_V  = DIVD_W'(NUM_RPM);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FREQ  = 8'b0000_0010,
        S_WFREQ = 8'b0000_0100,
        S_WRPM  = 8'b0000_1000,
        S_RING  = 8'b0001_0000,
        S_AVG   = 8'b0010_0000,
        S_WAVG  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [PP_W-1:0]      r_pp;
    logic [WIN_REG_W-1:0] r_win;
    logic                 r_en;
    logic [MS_W-1:0]      r_timeout;

    // tracking state
    logic [STAMP_BITS-1:0] r_prev;
    logic                  r_have;
    logic                  r_ever;
    logic [MS_W-1:0]       r_ms;
    logic [STAMP_BITS-1:0] r_period;
    logic [DIVS_W-1:0]     r_prod;

    // filter state
    logic [IDX_W-1:0] r_widx;
    logic [WIN_W-1:0] r_fill;
    logic [SUM_W-1:0] r_sum;

    // held results
    logic [RPM_W-1:0]  r_held_filt;
    logic [RPM_W-1:0]  r_held_raw;
    logic [FREQ_W-1:0] r_held_freq;
    logic              r_held_stop;
    logic              r_fresh;

    logic [STAMP_BITS-1:0] stamp_c;
    logic [STAMP_BITS-1:0] period_c;
    logic [MS_W-1:0]       ms_inc;
    logic [PP_W-1:0]       pp_eff;
    logic [WIN_W-1:0]      w_eff;
    logic                  bypass;
    logic                  ring_full;
    logic [RPM_W-1:0]      ring_rdata;
    logic [RPM_W-1:0]      old_sample;
    logic [WIN_W-1:0]      idx_inc;
    logic [DIVS_W-1:0]     prod_c;
    logic [FREQ_W-1:0]     freq_sat;
    logic [RPM_W-1:0]      rpm_sat;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;

    assign stamp_c  = i_capture_stamp[STAMP_BITS-1:0];
    assign period_c = stamp_c - r_prev;
    assign ms_inc   = (r_ms != MS_MAX) ? r_ms + MS_W'(1) : r_ms;
    assign pp_eff   = (r_pp == '0) ? PP_W'(1) : r_pp;
    assign prod_c   = r_period * pp_eff;

    always_comb begin
        if (r_win == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            w_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_eff = WIN_W'(r_win);
        end
    end

    assign bypass     = !r_en || (w_eff == WIN_W'(1));
    // an entry not yet written since the last clear reads as zero
    assign ring_full  = (r_fill == w_eff);
    assign old_sample = ring_full ? ring_rdata : '0;
    assign idx_inc    = WIN_W'(r_widx) + WIN_W'(1);

    assign freq_sat = (|div_quo[DIVD_W-1:FREQ_W]) ? '1 : div_quo[FREQ_W-1:0];
    assign rpm_sat  = (|div_quo[DIVD_W-1:RPM_W]) ? '1 : div_quo[RPM_W-1:0];

    always_comb begin
        div_start    = 1'b0;
        div_dividend = NUM_FREQ_V;
        div_divisor  = {{PP_W{1'b0}}, r_period};
        unique case (r_state)
            S_FREQ: begin
                div_start = 1'b1;
            end
            S_WFREQ: begin
                div_start    = div_done;
                div_dividend = NUM_RPM_V;
                div_divisor  = r_prod;
            end
            S_AVG: begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(r_sum);
                div_divisor  = DIVS_W'(r_fill);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tach_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (DIVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    tach_ram #(
        .WIDTH (RPM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RING),
        .i_waddr (r_widx),
        .i_wdata (r_held_raw),
        .i_raddr (r_widx),
        .o_rdata (ring_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pp        <= PP_RESET;
            r_win       <= WIN_RESET;
            r_en        <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_ever      <= 1'b0;
            r_ms        <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_held_filt <= '0;
            r_held_raw  <= '0;
            r_held_freq <= '0;
            r_held_stop <= 1'b0;
            r_fresh     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            if (i_cfg_wen) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_POLE_PAIRS: r_pp <= i_cfg_wdata[PP_W-1:0];
                    CFG_FILTER_WIN: begin
                        r_win  <= i_cfg_wdata[WIN_REG_W-1:0];
                        r_widx <= '0;
                        r_fill <= '0;
                        r_sum  <= '0;
                    end
                    CFG_FILTER_EN:    r_en      <= i_cfg_wdata[0];
                    CFG_STOP_TIMEOUT: r_timeout <= i_cfg_wdata[MS_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_OUT;
                        r_fresh <= 1'b0;
                        if (i_func == FUNC_TICK) begin
                            r_ms <= ms_inc;
                            if (r_ever && (ms_inc > r_timeout)) begin
                                r_held_filt <= '0;
                                r_held_raw  <= '0;
                                r_held_freq <= '0;
                                r_held_stop <= 1'b1;
                            end
                        end else begin
                            r_ever <= 1'b1;
                            r_ms   <= '0;
                            r_prev <= stamp_c;
                            r_have <= 1'b1;
                            if (r_have) begin
                                r_fresh <= 1'b1;
                                if (period_c == '0) begin
                                    r_held_filt <= '0;
                                    r_held_raw  <= '0;
                                    r_held_freq <= '0;
                                    r_held_stop <= 1'b1;
                                end else begin
                                    r_period <= period_c;
                                    r_state  <= S_FREQ;
                                end
                            end
                        end
                    end
                end
                S_FREQ: begin
                    r_prod  <= prod_c;
                    r_state <= S_WFREQ;
                end
                S_WFREQ: begin
                    if (div_done) begin
                        r_held_freq <= freq_sat;
                        r_state     <= S_WRPM;
                    end
                end
                S_WRPM: begin
                    if (div_done) begin
                        r_held_raw  <= rpm_sat;
                        r_held_stop <= 1'b0;
                        if (bypass) begin
                            r_held_filt <= rpm_sat;
                            r_state     <= S_OUT;
                        end else begin
                            r_state <= S_RING;
                        end
                    end
                end
                S_RING: begin
                    r_sum  <= r_sum + SUM_W'(r_held_raw) - SUM_W'(old_sample);
                    r_widx <= (idx_inc == w_eff) ? '0 : idx_inc[IDX_W-1:0];
                    if (!ring_full) begin
                        r_fill <= r_fill + WIN_W'(1);
                    end
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_WAVG;
                end
                S_WAVG: begin
                    if (div_done) begin
                        r_held_filt <= div_quo[RPM_W-1:0];
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!o_out_valid || i_out_ready)) begin
            o_filtered_rpm    <= r_held_filt;
            o_raw_rpm         <= r_held_raw;
            o_input_frequency <= r_held_freq;
            o_new_measurement <= r_fresh;
            o_stopped         <= r_held_stop;
        end
    end

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WFREQ || r_state == S_WRPM || r_state == S_WAVG))
        else $error("divider finished outside a wait state");

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= w_eff) && (WIN_W'(r_widx) < w_eff))
        else $error("ring fill count or write index beyond window");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("transaction taken while another is in work");

    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stopped) |->
            (o_raw_rpm == '0 && o_filtered_rpm == '0 && o_input_frequency == '0))
        else $error("stopped result carries nonzero values");

    a_sum_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_sum == '0))
        else $error("running sum nonzero with empty ring");

endmodule

`default_nettype wire

@@ src/tach_ram.sv @@
`default_nettype none

module tach_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/tach_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module tach_div #(
    parameter int DIVD_W = 45,
    parameter int DIVS_W = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVS_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   sub_c;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign sub_c  = rem_sh - {1'b0, r_dvs};
    // no borrow out of the top bit means the shifted remainder covers the divisor
    assign ge     = !sub_c[DIVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? sub_c[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ tb/tb_tach_rpm_meter_with_moving_average.sv @@
module tb_tach_rpm_meter_with_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import tach_pkg::*;

    localparam longint unsigned CLK_HZ   = longint'(CLOCK_HZ_DEF);
    localparam int              WIN_MAX  = MAX_WINDOW_DEF;
    localparam logic [63:0]     RPM_SAT  = (64'd1 << RPM_W) - 64'd1;
    localparam logic [63:0]     FREQ_SAT = (64'd1 << FREQ_W) - 64'd1;

    typedef struct packed {
        logic [RPM_W-1:0]  filtered;
        logic [RPM_W-1:0]  raw;
        logic [FREQ_W-1:0] freq;
        logic              fresh;
        logic              stopped;
    } reading_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        t_func       func;
        logic [31:0] val;
        t_cfg_idx    idx;
        logic        typed;
        reading_t    want;
    } plan_row_t;

    // readings that can be read straight off the spec
    localparam reading_t QUIET       = '{41'd0, 41'd0, 35'd0, 1'b0, 1'b0};
    localparam reading_t TIMED_OUT   = '{41'd0, 41'd0, 35'd0, 1'b0, 1'b1};
    localparam reading_t ZERO_PERIOD = '{41'd0, 41'd0, 35'd0, 1'b1, 1'b1};
    localparam reading_t FASTEST     = '{41'd1228800000000, 41'd1228800000000,
                                         35'd20480000000, 1'b1, 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_func;
    logic [STAMP_W-1:0]    i_capture_stamp;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [RPM_W-1:0]      o_filtered_rpm;
    logic [RPM_W-1:0]      o_raw_rpm;
    logic [FREQ_W-1:0]     o_input_frequency;
    logic                  o_new_measurement;
    logic                  o_stopped;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    tach_rpm_meter_with_moving_average i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_capture_stamp   (i_capture_stamp),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_rpm    (o_filtered_rpm),
        .o_raw_rpm         (o_raw_rpm),
        .o_input_frequency (o_input_frequency),
        .o_new_measurement (o_new_measurement),
        .o_stopped         (o_stopped),
        .i_cfg_wen         (i_cfg_wen),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    // predictor copy of registers and meter state
    logic [PP_W-1:0]      pp_reg       = PP_RESET;
    logic [WIN_REG_W-1:0] win_reg      = WIN_RESET;
    logic                 en_reg       = 1'b0;
    logic [MS_W-1:0]      tmo_reg      = TIMEOUT_RESET;
    logic [31:0]          last_stamp   = '0;
    bit                   primed       = 1'b0;
    bit                   seen_capture = 1'b0;
    logic [MS_W-1:0]      ms_count     = '0;
    logic [RPM_W-1:0]     rpm_ring [WIN_MAX] = '{default: '0};
    int                   wr_idx       = 0;
    int                   fill         = 0;
    logic [63:0]          rpm_sum      = '0;
    reading_t             held         = QUIET;

    reading_t  pending_readings [$];
    plan_row_t dir_plan [$];
    int        err_count = 0;
    bit        calm      = 1'b0;

    function automatic void cfg_model(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_POLE_PAIRS: pp_reg = data[PP_W-1:0];
            CFG_FILTER_WIN: begin
                win_reg  = data[WIN_REG_W-1:0];
                rpm_ring = '{default: '0};
                wr_idx   = 0;
                fill     = 0;
                rpm_sum  = '0;
            end
            CFG_FILTER_EN:    en_reg = data[0];
            CFG_STOP_TIMEOUT: tmo_reg = data[MS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic reading_t meter_predict(input t_func f, input logic [31:0] s);
        logic [31:0] period;
        logic [63:0] freq;
        logic [63:0] rpm;
        logic [63:0] pp;
        int          w;
        reading_t    res;
        logic        fresh;
        fresh = 1'b0;
        if (f == FUNC_CAPTURE) begin
            seen_capture = 1'b1;
            ms_count     = '0;
            if (primed) begin
                period = s - last_stamp;
                fresh  = 1'b1;
                if (period == 0) begin
                    held = ZERO_PERIOD;
                end else begin
                    pp   = (pp_reg == 0) ? 64'd1 : 64'(pp_reg);
                    freq = (CLK_HZ * 64'd256) / 64'(period);
                    rpm  = (CLK_HZ * 64'd15360) / (64'(period) * pp);
                    if (freq > FREQ_SAT) freq = FREQ_SAT;
                    if (rpm > RPM_SAT) rpm = RPM_SAT;
                    held.freq    = freq[FREQ_W-1:0];
                    held.raw     = rpm[RPM_W-1:0];
                    held.stopped = 1'b0;
                    w = (win_reg == 0) ? 1 : (win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg);
                    if (!en_reg || w == 1) begin
                        held.filtered = held.raw;
                    end else begin
                        if (wr_idx >= w) wr_idx = 0;
                        rpm_sum = rpm_sum - 64'(rpm_ring[wr_idx]) + rpm;
                        rpm_ring[wr_idx] = held.raw;
                        wr_idx = (wr_idx + 1) % w;
                        if (fill < w) fill++;
                        held.filtered = RPM_W'(rpm_sum / 64'(fill));
                    end
                end
            end
            last_stamp = s;
            primed     = 1'b1;
        end else begin
            if (ms_count != MS_MAX) ms_count++;
            if (seen_capture && ms_count > tmo_reg) held = TIMED_OUT;
        end
        res       = held;
        res.fresh = fresh;
        return res;
    endfunction

    task automatic send_item(input t_func f, input logic [31:0] s, input bit typed,
                             input reading_t want);
        reading_t got;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_capture_stamp <= s;
        do @(posedge i_clk); while (!o_in_ready);
        got = meter_predict(f, s);
        pending_readings.push_back(typed ? want : got);
    endtask

    // register writes go in only once every reading is out
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        cfg_model(idx, data);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin : check_readings
        reading_t exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected transaction: filt=%0d raw=%0d freq=%0d new=%0b stop=%0b",
                             o_filtered_rpm, o_raw_rpm, o_input_frequency,
                             o_new_measurement, o_stopped);
                err_count++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (o_filtered_rpm !== exp_r.filtered || o_raw_rpm !== exp_r.raw ||
                    o_input_frequency !== exp_r.freq || o_new_measurement !== exp_r.fresh ||
                    o_stopped !== exp_r.stopped) begin
                    if (err_count < 10) begin
                        $display("mismatch exp: filt=%0d raw=%0d freq=%0d new=%0b stop=%0b",
                                 exp_r.filtered, exp_r.raw, exp_r.freq, exp_r.fresh,
                                 exp_r.stopped);
                        $display("         got: filt=%0d raw=%0d freq=%0d new=%0b stop=%0b",
                                 o_filtered_rpm, o_raw_rpm, o_input_frequency,
                                 o_new_measurement, o_stopped);
                    end
                    err_count++;
                end
            end
        end
    end

    initial begin
        int          phase;
        int          n_items;
        int          r;
        int          sel;
        int          burst;
        logic [31:0] stamp_cursor;
        logic [31:0] gap;
        logic [7:0]  pp;
        logic [4:0]  win;
        logic [15:0] tmo;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FUNC_CAPTURE;
        i_capture_stamp = '0;
        i_cfg_wen       = 1'b0;
        i_cfg_idx       = CFG_POLE_PAIRS;
        i_cfg_wdata     = '0;

        dir_plan = '{
            // tick before any capture, priming capture, zero period, shortest period
            '{ROW_ITEM, FUNC_TICK,    32'h0000_0000, CFG_POLE_PAIRS, 1'b1, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h0000_0000, CFG_POLE_PAIRS, 1'b1, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h0000_0000, CFG_POLE_PAIRS, 1'b1, ZERO_PERIOD},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h0000_0001, CFG_POLE_PAIRS, 1'b1, FASTEST},
            // longest period, then wrap of the timer
            '{ROW_ITEM, FUNC_CAPTURE, 32'h0000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'hFFFF_FFFF, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h0000_0000, CFG_POLE_PAIRS, 1'b1, FASTEST},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_A5FF, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_0002, CFG_STOP_TIMEOUT, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd80000,     CFG_POLE_PAIRS, 1'b0, QUIET},
            // third tick passes the stop timeout
            '{ROW_ITEM, FUNC_TICK,    32'hFFFF_FFFF, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_TICK,    32'h0000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_TICK,    32'h5A5A_5A5A, CFG_POLE_PAIRS, 1'b1, TIMED_OUT},
            // pole pairs zero acts as one
            '{ROW_CFG,  FUNC_TICK,    32'h0000_3C00, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_0010, CFG_FILTER_WIN, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_FFFF, CFG_FILTER_EN,  1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd160000,    CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd160001,    CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd240001,    CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd240001,    CFG_POLE_PAIRS, 1'b1, ZERO_PERIOD},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd320001,    CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_TICK,    32'h0000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            // window zero bypasses the average, window above max clamps
            '{ROW_CFG,  FUNC_TICK,    32'h0000_0000, CFG_FILTER_WIN, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'd400000,    CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_001F, CFG_FILTER_WIN, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_FFFF, CFG_STOP_TIMEOUT, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h8000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h8000_3039, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_TICK,    32'h0000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_ITEM, FUNC_TICK,    32'h0000_0000, CFG_POLE_PAIRS, 1'b0, QUIET},
            '{ROW_CFG,  FUNC_TICK,    32'h0000_0000, CFG_FILTER_EN,  1'b0, QUIET},
            '{ROW_ITEM, FUNC_CAPTURE, 32'h8001_0000, CFG_POLE_PAIRS, 1'b0, QUIET}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_plan[k]) begin
            if (dir_plan[k].kind == ROW_CFG)
                cfg_write(dir_plan[k].idx, dir_plan[k].val[CFG_DATA_W-1:0]);
            else
                send_item(dir_plan[k].func, dir_plan[k].val, dir_plan[k].typed,
                          dir_plan[k].want);
        end

        stamp_cursor = last_stamp;
        for (phase = 0; phase < 10; phase++) begin
            pp  = (phase == 0) ? 8'd1 : (phase == 1) ? 8'd255 : (phase == 2) ? 8'd0 :
                  8'($urandom_range(255));
            case (phase % 5)
                0:       win = 5'd16;
                1:       win = 5'd1;
                2:       win = 5'd31;
                3:       win = 5'd0;
                default: win = 5'($urandom_range(2, 15));
            endcase
            tmo = (phase == 3) ? 16'hFFFF : (phase == 6) ? 16'd1 : 16'($urandom_range(2, 30));
            cfg_write(CFG_POLE_PAIRS, {8'($urandom), pp});
            cfg_write(CFG_FILTER_WIN, {11'($urandom), win});
            cfg_write(CFG_FILTER_EN, {15'($urandom), 1'(phase % 3 != 2)});
            cfg_write(CFG_STOP_TIMEOUT, tmo);

            // one whole phase without any idling on either side
            calm    = (phase == 4);
            n_items = 0;
            while (n_items < 200) begin
                r = $urandom_range(99);
                if (r < 62) begin
                    sel = $urandom_range(19);
                    if (sel < 1)       gap = 32'd0;
                    else if (sel < 4)  gap = $urandom_range(1, 255);
                    else if (sel < 12) gap = $urandom_range(1000, 2_000_000);
                    else if (sel < 16) gap = $urandom;
                    else if (sel < 18) gap = 32'hFFFF_FF00 | $urandom_range(255);
                    else               gap = 32'd80000 + $urandom_range(63);
                    stamp_cursor = stamp_cursor + gap;
                    send_item(FUNC_CAPTURE, stamp_cursor, 1'b0, QUIET);
                    n_items++;
                end else if (r < 74) begin
                    stamp_cursor = $urandom;
                    send_item(FUNC_CAPTURE, stamp_cursor, 1'b0, QUIET);
                    n_items++;
                end else begin
                    // some bursts are long enough to run into the stop timeout
                    if ($urandom_range(3) == 0 && tmo_reg <= 40)
                        burst = int'(tmo_reg) + int'($urandom_range(2));
                    else
                        burst = $urandom_range(1, 5);
                    repeat (burst) begin
                        send_item(FUNC_TICK, $urandom, 1'b0, QUIET);
                        n_items++;
                    end
                end
            end
            calm = 1'b0;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
